// ===== design/gmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmd_pkg
// shared types, constants and the control store of the maze search sequencer
// ----------------------------------------------------------------------------
package gmd_pkg;

	// grid geometry
	localparam int GRID_SIDE  = 8;
	localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
	localparam int POS_W      = $clog2(GRID_SIDE);
	localparam int IDX_W      = $clog2(CELL_COUNT);
	localparam int DEPTH_W    = $clog2(CELL_COUNT + 1);
	localparam int STK_W      = 2 * POS_W;

	// fixed field widths of the stream ports
	localparam int COORD_W     = 3;
	localparam int MARK_W      = 2;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 8;

	// configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_ENTRY_ROW    = 1'b0;
	localparam logic REG_ENTRY_COLUMN = 1'b1;
	localparam logic [COORD_W-1:0] ENTRY_ROW_RESET    = 3'd5;
	localparam logic [COORD_W-1:0] ENTRY_COLUMN_RESET = 3'd2;

	// cell marks
	localparam logic [MARK_W-1:0] MARK_WALL    = 2'd0;
	localparam logic [MARK_W-1:0] MARK_OPEN    = 2'd1;
	localparam logic [MARK_W-1:0] MARK_VISITED = 2'd2;
	localparam logic [MARK_W-1:0] MARK_DEAD    = 2'd3;

	// neighbor order
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	// datapath operations
	typedef enum logic [2:0] {
		OP_WAIT,
		OP_START,
		OP_TOP,
		OP_TOPD,
		OP_NREAD,
		OP_NCHK,
		OP_EREAD,
		OP_EOUT
	} op_t;

	// jump conditions
	typedef enum logic [3:0] {
		C_ALWAYS,
		C_NEVER,
		C_NO_RUN,
		C_OUT_BUSY,
		C_ENTRY_BAD,
		C_EMPTY,
		C_LAST_COL,
		C_NB_DONE,
		C_LAST_EMIT
	} cond_t;

	// control store addresses
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_TOP,
		ST_TOPD,
		ST_NREAD,
		ST_NCHK,
		ST_EREAD,
		ST_EOUT
	} step_t;

	typedef struct packed {
		op_t   op;
		cond_t hold;
		cond_t cond;
		step_t tgt_t;
		step_t tgt_f;
	} ctl_word_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic run_taken;
		logic entry_bad;
		logic empty;
		logic last_col;
		logic nb_done;
		logic last_emit;
		logic out_busy;
	} status_t;

	// control store: hold keeps the step, else cond picks tgt_t or tgt_f
	function automatic ctl_word_t ucode(step_t s);
		ctl_word_t w;
		w = '{op: OP_WAIT, hold: C_NEVER, cond: C_ALWAYS, tgt_t: ST_IDLE, tgt_f: ST_IDLE};
		unique case (s)
			ST_IDLE:  w = '{op: OP_WAIT,  hold: C_NO_RUN,   cond: C_ALWAYS,
				tgt_t: ST_START, tgt_f: ST_START};
			ST_START: w = '{op: OP_START, hold: C_NEVER,    cond: C_ENTRY_BAD,
				tgt_t: ST_EREAD, tgt_f: ST_TOP};
			ST_TOP:   w = '{op: OP_TOP,   hold: C_NEVER,    cond: C_EMPTY,
				tgt_t: ST_EREAD, tgt_f: ST_TOPD};
			ST_TOPD:  w = '{op: OP_TOPD,  hold: C_NEVER,    cond: C_LAST_COL,
				tgt_t: ST_EREAD, tgt_f: ST_NREAD};
			ST_NREAD: w = '{op: OP_NREAD, hold: C_NEVER,    cond: C_ALWAYS,
				tgt_t: ST_NCHK,  tgt_f: ST_NCHK};
			ST_NCHK:  w = '{op: OP_NCHK,  hold: C_NEVER,    cond: C_NB_DONE,
				tgt_t: ST_TOP,   tgt_f: ST_NREAD};
			ST_EREAD: w = '{op: OP_EREAD, hold: C_NEVER,    cond: C_ALWAYS,
				tgt_t: ST_EOUT,  tgt_f: ST_EOUT};
			ST_EOUT:  w = '{op: OP_EOUT,  hold: C_OUT_BUSY, cond: C_LAST_EMIT,
				tgt_t: ST_IDLE,  tgt_f: ST_EREAD};
			default: ;
		endcase
		return w;
	endfunction

	function automatic logic range_ok(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
		return (int'(r) < GRID_SIDE) && (int'(c) < GRID_SIDE);
	endfunction

	function automatic logic [POS_W-1:0] to_pos(logic [COORD_W-1:0] v);
		return POS_W'(v);
	endfunction

	function automatic logic [IDX_W-1:0] cell_idx(logic [POS_W-1:0] r, logic [POS_W-1:0] c);
		return IDX_W'(int'(r) * GRID_SIDE + int'(c));
	endfunction

endpackage

// ===== design/grid_maze_depth_first_search.sv =====
`timescale 1ns / 1ps
// load item: a new load may follow every cycle while s_tready is high (idle step)
// run item: START, then TOP/TOPD per stack look and NREAD/NCHK per neighbor tried,
//   then EREAD/EOUT per emitted cell (64 cells, EOUT holds while m_tready is low)
// each step pair is an address step and a data step of the registered-read memories
// reset clears the step counter, stack depth, flags and output valid; grid
// and stack memories are not cleared and hold garbage until loaded
// ----------------------------------------------------------------------------
// grid_maze_depth_first_search
// depth-first maze solver: microcoded sequencer over a grid and stack datapath
// ----------------------------------------------------------------------------
module grid_maze_depth_first_search import gmd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// cell load / run stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // cell_row[2:0], cell_column[5:3], cell_open[6]
	input  logic [0:0]             s_tuser,   // kind[0]
	// mark stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // cell_mark[1:0], path_found[2]
	output logic                   m_tlast,   // last_cell
	// configuration
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_AW-1:0]      paddr,
	input  logic [APB_DW-1:0]      pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	logic [COORD_W-1:0] entry_row_q;
	logic [COORD_W-1:0] entry_col_q;
	logic               cfg_wr;
	op_t                op;
	status_t            status;

	// apb registers, one word each, decoded on the word address bit
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_row_q <= ENTRY_ROW_RESET;
			entry_col_q <= ENTRY_COLUMN_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ENTRY_ROW:    entry_row_q <= pwdata[COORD_W-1:0];
				REG_ENTRY_COLUMN: entry_col_q <= pwdata[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ENTRY_ROW:    prdata = APB_DW'(entry_row_q);
			REG_ENTRY_COLUMN: prdata = APB_DW'(entry_col_q);
			default:          prdata = '0;
		endcase
	end

	// control store walks the search and the readout
	gmd_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.op     (op)
	);

	// grid, stack and output register
	gmd_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.entry_row    (entry_row_q),
		.entry_column (entry_col_q),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.status       (status)
	);

	// a run transfer closes the input until the grid has been read out
	a_run_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[0]) |=> !s_tready)
		else $error("input still open after run transfer");

	// an emit step with a free output register always presents a cell
	a_emit_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_EOUT && !status.out_busy) |=> m_tvalid)
		else $error("emit step did not load output register");

	// path flag stays the same across all cells of one readout
	a_found_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
		(!m_tvalid || (m_tdata[2] == $past(m_tdata[2]))))
		else $error("path flag changed within one readout");

	// a stalled cell keeps its payload until it is taken
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=>
		(m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("cell payload changed while stalled");

endmodule

// ===== design/gmd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmd_ram
// generic one write port, one read port ram with registered read data
// ----------------------------------------------------------------------------
module gmd_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/gmd_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmd_sequencer
// step counter over the control store with conditional jumps
// ----------------------------------------------------------------------------
module gmd_sequencer import gmd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output op_t     op
);

	step_t     pc_q;
	step_t     pc_d;
	ctl_word_t cw;
	logic      hold;
	logic      take;

	function automatic logic cond_met(cond_t c, status_t st);
		logic r;
		r = 1'b0;
		case (c)
			C_ALWAYS:    r = 1'b1;
			C_NEVER:     r = 1'b0;
			C_NO_RUN:    r = !st.run_taken;
			C_OUT_BUSY:  r = st.out_busy;
			C_ENTRY_BAD: r = st.entry_bad;
			C_EMPTY:     r = st.empty;
			C_LAST_COL:  r = st.last_col;
			C_NB_DONE:   r = st.nb_done;
			C_LAST_EMIT: r = st.last_emit;
			default:     r = 1'b0;
		endcase
		return r;
	endfunction

	always_comb begin
		cw   = ucode(pc_q);
		hold = cond_met(cw.hold, status);
		take = cond_met(cw.cond, status);
		if (hold) begin
			pc_d = pc_q;
		end else if (take) begin
			pc_d = cw.tgt_t;
		end else begin
			pc_d = cw.tgt_f;
		end
	end

	assign op = cw.op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

// ===== design/gmd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmd_datapath
// grid and stack memories, search registers and the output register
// ----------------------------------------------------------------------------
module gmd_datapath import gmd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  op_t                    op,
	input  logic [COORD_W-1:0]     entry_row,
	input  logic [COORD_W-1:0]     entry_column,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic [0:0]             s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast,
	output status_t                status
);

	logic               in_kind;
	logic [COORD_W-1:0] in_row;
	logic [COORD_W-1:0] in_col;
	logic               in_open;
	logic               in_take;
	logic               entry_bad;

	logic [POS_W-1:0]   cur_r_q, cur_c_q, nb_r_q, nb_c_q;
	logic [POS_W-1:0]   nb_r, nb_c;
	logic               nb_ok, nb_ok_q, nb_hit, nb_done;
	logic [1:0]         dir_q;
	logic [DEPTH_W-1:0] depth_q;
	logic               found_q;
	logic [IDX_W-1:0]   ecnt_q;
	logic               last_emit;
	logic               out_busy;
	logic               out_load;

	logic               m_valid_q;
	logic [MARK_W-1:0]  m_mark_q;
	logic               m_found_q;
	logic               m_last_q;

	logic               g_we;
	logic [IDX_W-1:0]   g_waddr, g_raddr;
	logic [MARK_W-1:0]  g_wdata, g_rdata;
	logic               stk_we;
	logic [IDX_W-1:0]   stk_waddr, stk_raddr;
	logic [STK_W-1:0]   stk_wdata, stk_rdata;
	logic [POS_W-1:0]   stk_r, stk_c;
	logic               last_col;

	// input fields
	assign in_kind = s_tuser[0];
	assign in_row  = s_tdata[2:0];
	assign in_col  = s_tdata[5:3];
	assign in_open = s_tdata[6];

	assign s_tready  = (op == OP_WAIT);
	assign in_take   = s_tvalid && s_tready;
	assign entry_bad = !range_ok(entry_row, entry_column);

	assign stk_r    = stk_rdata[STK_W-1:POS_W];
	assign stk_c    = stk_rdata[POS_W-1:0];
	assign last_col = (stk_c == POS_W'(GRID_SIDE - 1));

	// neighbor in the current direction
	always_comb begin
		nb_r  = cur_r_q;
		nb_c  = cur_c_q;
		nb_ok = 1'b0;
		case (dir_q)
			DIR_UP: begin
				nb_ok = (cur_r_q != '0);
				nb_r  = cur_r_q - POS_W'(1);
			end
			DIR_DOWN: begin
				nb_ok = (cur_r_q != POS_W'(GRID_SIDE - 1));
				nb_r  = cur_r_q + POS_W'(1);
			end
			DIR_LEFT: begin
				nb_ok = (cur_c_q != '0);
				nb_c  = cur_c_q - POS_W'(1);
			end
			default: begin
				nb_ok = (cur_c_q != POS_W'(GRID_SIDE - 1));
				nb_c  = cur_c_q + POS_W'(1);
			end
		endcase
	end

	assign nb_hit    = nb_ok_q && (g_rdata == MARK_OPEN);
	assign nb_done   = nb_hit || (dir_q == DIR_RIGHT);
	assign last_emit = (ecnt_q == IDX_W'(CELL_COUNT - 1));
	assign out_busy  = m_valid_q && !m_tready;
	assign out_load  = (op == OP_EOUT) && !out_busy;

	// memory ports
	always_comb begin
		g_we      = 1'b0;
		g_waddr   = '0;
		g_wdata   = MARK_WALL;
		g_raddr   = ecnt_q;
		stk_we    = 1'b0;
		stk_waddr = '0;
		stk_wdata = '0;
		stk_raddr = IDX_W'(depth_q - DEPTH_W'(1));
		case (op)
			OP_WAIT: begin
				if (in_take && !in_kind && range_ok(in_row, in_col)) begin
					g_we    = 1'b1;
					g_waddr = cell_idx(to_pos(in_row), to_pos(in_col));
					g_wdata = in_open ? MARK_OPEN : MARK_WALL;
				end
			end
			OP_START: begin
				if (!entry_bad) begin
					g_we      = 1'b1;
					g_waddr   = cell_idx(to_pos(entry_row), to_pos(entry_column));
					g_wdata   = MARK_VISITED;
					stk_we    = 1'b1;
					stk_waddr = '0;
					stk_wdata = {to_pos(entry_row), to_pos(entry_column)};
				end
			end
			OP_NREAD: begin
				g_raddr = cell_idx(nb_r, nb_c);
			end
			OP_NCHK: begin
				if (nb_hit) begin
					g_we    = 1'b1;
					g_waddr = cell_idx(nb_r_q, nb_c_q);
					g_wdata = MARK_VISITED;
					if (depth_q < DEPTH_W'(CELL_COUNT)) begin
						stk_we    = 1'b1;
						stk_waddr = IDX_W'(depth_q);
						stk_wdata = {nb_r_q, nb_c_q};
					end
				end else if (dir_q == DIR_RIGHT) begin
					g_we    = 1'b1;
					g_waddr = cell_idx(cur_r_q, cur_c_q);
					g_wdata = MARK_DEAD;
				end
			end
			default: ;
		endcase
	end

	gmd_ram #(.WIDTH(MARK_W), .DEPTH(CELL_COUNT)) u_grid (
		.clk   (clk),
		.we    (g_we),
		.waddr (g_waddr),
		.wdata (g_wdata),
		.raddr (g_raddr),
		.rdata (g_rdata)
	);

	gmd_ram #(.WIDTH(STK_W), .DEPTH(CELL_COUNT)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= '0;
			found_q   <= 1'b0;
			dir_q     <= DIR_UP;
			ecnt_q    <= '0;
			nb_ok_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			case (op)
				OP_START: begin
					depth_q <= entry_bad ? DEPTH_W'(0) : DEPTH_W'(1);
					found_q <= 1'b0;
					ecnt_q  <= '0;
				end
				OP_TOPD: begin
					dir_q   <= DIR_UP;
					found_q <= last_col;
				end
				OP_NREAD: begin
					nb_ok_q <= nb_ok;
				end
				OP_NCHK: begin
					if (nb_hit) begin
						if (depth_q < DEPTH_W'(CELL_COUNT)) begin
							depth_q <= depth_q + DEPTH_W'(1);
						end
					end else if (dir_q == DIR_RIGHT) begin
						depth_q <= depth_q - DEPTH_W'(1);
					end else begin
						dir_q <= dir_q + 2'd1;
					end
				end
				OP_EOUT: begin
					if (out_load) begin
						ecnt_q <= ecnt_q + IDX_W'(1);
					end
				end
				default: ;
			endcase
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (op == OP_TOPD) begin
			cur_r_q <= stk_r;
			cur_c_q <= stk_c;
		end
		if (op == OP_NREAD) begin
			nb_r_q <= nb_r;
			nb_c_q <= nb_c;
		end
		if (out_load) begin
			m_mark_q  <= g_rdata;
			m_found_q <= found_q;
			m_last_q  <= last_emit;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(OUT_TDATA_W - MARK_W - 1)'(0), m_found_q, m_mark_q};
	assign m_tlast  = m_last_q;

	assign status = '{
		run_taken: in_take && in_kind,
		entry_bad: entry_bad,
		empty:     (depth_q == '0),
		last_col:  last_col,
		nb_done:   nb_done,
		last_emit: last_emit,
		out_busy:  out_busy
	};

endmodule
